@@ sv/integral_image_sum_square_tilted_assert.svh @@
// Assertion macros shared by the integral image RTL.
`ifndef INTEGRAL_IMAGE_SUM_SQUARE_TILTED_ASSERT_SVH
`define INTEGRAL_IMAGE_SUM_SQUARE_TILTED_ASSERT_SVH

// Plain property check, clocked on clk_i, off while rst_ni is low.
`define IIST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition a at one edge implies b at the next edge.
`define IIST_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error(msg);

`endif

@@ sv/iist_pkg.sv @@
package iist_pkg;

  localparam int PIX_W  = 8;
  localparam int SUM_W  = 30;
  localparam int SQ_W   = 38;
  localparam int TILT_W = 30;
  localparam int LSUM_W = 31;
  localparam int LSQ_W  = 39;
  localparam int RSUM_W = 19;
  localparam int RSQ_W  = 27;
  localparam int CFG_W  = 12;
  localparam int CHAN_W = 3;
  localparam int ODATA_W = SUM_W + SQ_W + TILT_W + TILT_W;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_e;

  localparam logic [CFG_W-1:0]  RST_IMAGE_WIDTH   = 12'd640;
  localparam logic [CFG_W-1:0]  RST_IMAGE_HEIGHT  = 12'd480;
  localparam logic [CHAN_W-1:0] RST_CHANNEL_COUNT = 3'd1;

  typedef struct packed {
    logic              frame_end;
    logic              row_end;
    logic [TILT_W-1:0] tilted_border;
    logic [TILT_W-1:0] tilted_sum;
    logic [SQ_W-1:0]   square_sum;
    logic [SUM_W-1:0]  upright_sum;
  } out_item_t;

endpackage

@@ sv/integral_image_sum_square_tilted.sv @@
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: pixel
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: sums, tlast: row_end, tuser: frame_end
// cfg      in   cfg_we_i (no wait)           cfg_addr_i selects the register
//
// Sustains one item per clock while the result queue has room; each item is registered
// in stage 1 and then in the result queue. Line stores are single-port-write RAMs read the
// cycle an item is accepted and written back in the cycle after; same-entry reuse by back-to-back items is forwarded.
// The diagonal store is split into even/odd column banks so two writes fit a cycle.
// A three-item result queue absorbs output stalls; input stalls when it and stage 1 hold three items.
// Reset clears counters, per-channel registers and config; line RAMs are not
// cleared, the first row of a frame reads them as zero.
`include "integral_image_sum_square_tilted_assert.svh"

module integral_image_sum_square_tilted
  import iist_pkg::*;
#(
  parameter int LINE_SIZE    = 2048,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_ROWS     = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PIX_W-1:0]    s_axis_tdata,   // [7:0] pixel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [29:0] upright_sum, [67:30] square_sum, [97:68] tilted_sum, [127:98] tilted_border
  output logic [ODATA_W-1:0]  m_axis_tdata,
  output logic                m_axis_tlast,   // row_end
  output logic [0:0]          m_axis_tuser,   // [0] frame_end
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  localparam int AW = $clog2(LINE_SIZE);
  localparam int CW = $clog2(LINE_SIZE + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int KW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;
  localparam int EH = (HW > CFG_W) ? HW : CFG_W;
  localparam int CH_LIM = (MAX_CHANNELS < LINE_SIZE) ? MAX_CHANNELS : LINE_SIZE;
  localparam logic [CHAN_W-1:0] CH_LIM3 = CHAN_W'(CH_LIM);
  localparam logic [CW-1:0] LIM1 = CW'(LINE_SIZE / 1);
  localparam logic [CW-1:0] LIM2 = CW'(LINE_SIZE / 2);
  localparam logic [CW-1:0] LIM3 = CW'(LINE_SIZE / 3);
  localparam logic [CW-1:0] LIM4 = CW'(LINE_SIZE / 4);
  localparam logic [HW-1:0] HMAX = HW'(MAX_ROWS);
  localparam int FIFO_D = 3;

  // configuration
  logic [CFG_W-1:0]  cfg_w_q, cfg_h_q;
  logic [CHAN_W-1:0] cfg_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= RST_IMAGE_WIDTH;
      cfg_h_q <= RST_IMAGE_HEIGHT;
      cfg_n_q <= RST_CHANNEL_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_IMAGE_WIDTH:   cfg_w_q <= cfg_wdata_i;
        REG_IMAGE_HEIGHT:  cfg_h_q <= cfg_wdata_i;
        REG_CHANNEL_COUNT: cfg_n_q <= cfg_wdata_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CHAN_W-1:0] n_raw, n_eff;
  logic [CW-1:0]     lim, w_eff;
  logic [CFG_W-1:0]  w_raw, h_raw;
  logic [HW-1:0]     h_eff;

  always_comb begin
    n_raw = (cfg_n_q == '0) ? CHAN_W'(1) : cfg_n_q;
    n_eff = (n_raw > CH_LIM3) ? CH_LIM3 : n_raw;
    case (n_eff)
      3'd1:    lim = LIM1;
      3'd2:    lim = LIM2;
      3'd3:    lim = LIM3;
      default: lim = LIM4;
    endcase
    w_raw = (cfg_w_q == '0) ? CFG_W'(1) : cfg_w_q;
    w_eff = (EW'(w_raw) > EW'(lim)) ? lim : CW'(w_raw);
    h_raw = (cfg_h_q == '0) ? CFG_W'(1) : cfg_h_q;
    h_eff = (EH'(h_raw) > EH'(HMAX)) ? HMAX : HW'(h_raw);
  end

  // position counters and address generation (accept cycle)
  logic [CW-1:0] col_q, c_sel, c_nxt, c_prv;
  logic [HW-1:0] row_q, y_sel;
  logic [KW-1:0] chan_q, k_sel;
  logic          last_k, last_c, last_y, acc;
  logic [AW-1:0] here, idx_c, idx_n, idx_p, rd0_addr, rd1_addr;
  logic [2:0]    occ;
  logic [1:0]    count_q;
  logic          s1_v_q;

  assign occ           = {1'b0, count_q} + 3'(s1_v_q);
  assign s_axis_tready = (occ < 3'(FIFO_D));
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    c_sel  = (col_q >= w_eff) ? '0 : col_q;
    k_sel  = (CHAN_W'(chan_q) >= n_eff) ? '0 : chan_q;
    y_sel  = (row_q >= h_eff) ? '0 : row_q;
    last_k = (CHAN_W'(k_sel) + CHAN_W'(1)) == n_eff;
    last_c = CW'(c_sel + CW'(1)) == w_eff;
    last_y = HW'(y_sel + HW'(1)) == h_eff;
    c_nxt  = c_sel + CW'(1);
    c_prv  = c_sel - CW'(1);
    here   = AW'(c_sel * n_eff) + AW'(k_sel);
    idx_c  = AW'((c_sel >> 1) * n_eff) + AW'(k_sel);
    idx_n  = AW'((c_nxt >> 1) * n_eff) + AW'(k_sel);
    idx_p  = AW'((c_prv >> 1) * n_eff) + AW'(k_sel);
    // column c lives in bank c[0], its neighbors in the other bank
    rd0_addr = c_sel[0] ? idx_n : idx_c;
    rd1_addr = c_sel[0] ? idx_c : idx_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      chan_q <= '0;
    end else if (acc) begin
      if (last_k) begin
        chan_q <= '0;
        if (last_c) begin
          col_q <= '0;
          row_q <= last_y ? '0 : HW'(y_sel + HW'(1));
        end else begin
          col_q <= c_nxt;
          row_q <= y_sel;
        end
      end else begin
        chan_q <= KW'(k_sel + KW'(1));
        col_q  <= c_sel;
        row_q  <= y_sel;
      end
    end
  end

  // stage 1 item registers
  logic [PIX_W-1:0] s1_p_q;
  logic [KW-1:0]    s1_k_q;
  logic             s1_first_q, s1_last_q, s1_multi_q, s1_live_q;
  logic             s1_row_end_q, s1_frame_end_q, s1_par_q;
  logic [AW-1:0]    s1_here_q, s1_idx_c_q, s1_idx_p_q, s1_rd0_q, s1_rd1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_p_q         <= s_axis_tdata;
      s1_k_q         <= k_sel;
      s1_first_q     <= (c_sel == '0);
      s1_last_q      <= last_c;
      s1_multi_q     <= (w_eff > CW'(1));
      s1_live_q      <= (y_sel != '0);
      s1_row_end_q   <= last_k && last_c;
      s1_frame_end_q <= last_k && last_c && last_y;
      s1_par_q       <= c_sel[0];
      s1_here_q      <= here;
      s1_idx_c_q     <= idx_c;
      s1_idx_p_q     <= idx_p;
      s1_rd0_q       <= rd0_addr;
      s1_rd1_q       <= rd1_addr;
    end
  end

  // line stores
  logic [LSUM_W-1:0] sum_mem   [LINE_SIZE];
  logic [LSQ_W-1:0]  sq_mem    [LINE_SIZE];
  logic [LSUM_W-1:0] tilt_mem  [LINE_SIZE];
  logic [LSUM_W-1:0] diag0_mem [LINE_SIZE];
  logic [LSUM_W-1:0] diag1_mem [LINE_SIZE];

  logic [LSUM_W-1:0] sum_rd_q, tilt_rd_q, diag0_rd_q, diag1_rd_q;
  logic [LSQ_W-1:0]  sq_rd_q;

  logic [LSUM_W-1:0] up, tl, bank0_wd, bank1_wd;
  logic [LSQ_W-1:0]  sq;
  logic [1:0]        bank_we;
  logic [AW-1:0]     bank0_wa, bank1_wa;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      sum_rd_q  <= sum_mem[here];
      sq_rd_q   <= sq_mem[here];
      tilt_rd_q <= tilt_mem[here];
    end
    if (s1_v_q) begin
      sum_mem[s1_here_q]  <= up;
      sq_mem[s1_here_q]   <= sq;
      tilt_mem[s1_here_q] <= tl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      diag0_rd_q <= diag0_mem[rd0_addr];
    end
    if (bank_we[0]) begin
      diag0_mem[bank0_wa] <= bank0_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      diag1_rd_q <= diag1_mem[rd1_addr];
    end
    if (bank_we[1]) begin
      diag1_mem[bank1_wa] <= bank1_wd;
    end
  end

  // forwarding of writes made on the same edge as the read
  logic              fw_v_q;
  logic [AW-1:0]     fw_addr_q, dfw0_addr_q, dfw1_addr_q;
  logic [LSUM_W-1:0] fw_sum_q, fw_tl_q, dfw0_data_q, dfw1_data_q;
  logic [LSQ_W-1:0]  fw_sq_q;
  logic [1:0]        dfw_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_v_q  <= 1'b0;
      dfw_v_q <= '0;
    end else begin
      fw_v_q  <= s1_v_q;
      dfw_v_q <= bank_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fw_addr_q   <= s1_here_q;
    fw_sum_q    <= up;
    fw_sq_q     <= sq;
    fw_tl_q     <= tl;
    dfw0_addr_q <= bank0_wa;
    dfw0_data_q <= bank0_wd;
    dfw1_addr_q <= bank1_wa;
    dfw1_data_q <= bank1_wd;
  end

  // per-channel running state
  logic [RSUM_W-1:0] rrs_q  [MAX_CHANNELS];
  logic [RSQ_W-1:0]  rrsq_q [MAX_CHANNELS];
  logic [PIX_W-1:0]  prev_q [MAX_CHANNELS];
  logic [LSUM_W-1:0] held_q [MAX_CHANNELS];

  logic              fw_hit;
  logic [LSUM_W-1:0] sum_above, above_t, d0, d1, diag_here, right, p31, diag_prv;
  logic [LSQ_W-1:0]  sq_above;
  logic [15:0]       pp;
  logic [RSUM_W-1:0] rs;
  logic [RSQ_W-1:0]  rsq;
  logic [LSUM_W-1:0] border;

  always_comb begin
    fw_hit    = fw_v_q && (fw_addr_q == s1_here_q);
    sum_above = s1_live_q ? (fw_hit ? fw_sum_q : sum_rd_q) : '0;
    sq_above  = s1_live_q ? (fw_hit ? fw_sq_q : sq_rd_q) : '0;
    above_t   = s1_live_q ? (fw_hit ? fw_tl_q : tilt_rd_q) : '0;
    d0 = (dfw_v_q[0] && (dfw0_addr_q == s1_rd0_q)) ? dfw0_data_q : diag0_rd_q;
    d1 = (dfw_v_q[1] && (dfw1_addr_q == s1_rd1_q)) ? dfw1_data_q : diag1_rd_q;
    diag_here = s1_live_q ? (s1_par_q ? d1 : d0) : '0;
    right     = s1_live_q ? (s1_par_q ? d0 : d1) : '0;
    p31 = LSUM_W'(s1_p_q);
    pp  = 16'(s1_p_q) * 16'(s1_p_q);

    rs  = s1_first_q ? RSUM_W'(s1_p_q) : rrs_q[s1_k_q] + RSUM_W'(s1_p_q);
    rsq = s1_first_q ? RSQ_W'(pp) : rrsq_q[s1_k_q] + RSQ_W'(pp);
    up  = sum_above + LSUM_W'(rs);
    sq  = sq_above + LSQ_W'(rsq);

    diag_prv = diag_here + LSUM_W'(prev_q[s1_k_q]);
    if (s1_first_q) begin
      tl     = above_t + p31 + (s1_multi_q ? right : '0);
      border = above_t;
    end else if (!s1_last_q) begin
      tl     = diag_here + right + p31 + held_q[s1_k_q];
      border = '0;
    end else begin
      tl     = diag_here + p31 + held_q[s1_k_q];
      border = '0;
    end

    // column c-1 goes to the other bank, the last-column pixel to bank c[0]
    bank_we  = '0;
    bank0_wa = s1_idx_c_q;
    bank1_wa = s1_idx_c_q;
    bank0_wd = p31;
    bank1_wd = p31;
    if (s1_par_q) begin
      bank_we[1] = s1_v_q && !s1_first_q && s1_last_q;
      bank_we[0] = s1_v_q && !s1_first_q;
      bank0_wa   = s1_idx_p_q;
      bank0_wd   = diag_prv;
    end else begin
      bank_we[0] = s1_v_q && !s1_first_q && s1_last_q;
      bank_we[1] = s1_v_q && !s1_first_q;
      bank1_wa   = s1_idx_p_q;
      bank1_wd   = diag_prv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        rrs_q[i]  <= '0;
        rrsq_q[i] <= '0;
        prev_q[i] <= '0;
        held_q[i] <= '0;
      end
    end else if (s1_v_q) begin
      rrs_q[s1_k_q]  <= rs;
      rrsq_q[s1_k_q] <= rsq;
      prev_q[s1_k_q] <= s1_p_q;
      held_q[s1_k_q] <= above_t;
    end
  end

  // result queue
  out_item_t  fifo_q [FIFO_D];
  out_item_t  push_item, head;
  logic [1:0] wp_q, rp_q;
  logic       pop;

  always_comb begin
    push_item.upright_sum   = up[SUM_W-1:0];
    push_item.square_sum    = sq[SQ_W-1:0];
    push_item.tilted_sum    = tl[TILT_W-1:0];
    push_item.tilted_border = border[TILT_W-1:0];
    push_item.row_end       = s1_row_end_q;
    push_item.frame_end     = s1_frame_end_q;
  end

  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      if (s1_v_q) begin
        wp_q <= (wp_q == 2'(FIFO_D - 1)) ? '0 : wp_q + 2'd1;
      end
      if (pop) begin
        rp_q <= (rp_q == 2'(FIFO_D - 1)) ? '0 : rp_q + 2'd1;
      end
      count_q <= 2'(count_q + 2'(s1_v_q) - 2'(pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      fifo_q[wp_q] <= push_item;
    end
  end

  assign head          = fifo_q[rp_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {head.tilted_border, head.tilted_sum, head.square_sum,
                          head.upright_sum};
  assign m_axis_tlast  = head.row_end;
  assign m_axis_tuser  = head.frame_end;

  `IIST_ASSERT(a_queue_room, occ <= 3'(FIFO_D), "result queue overcommitted")
  `IIST_ASSERT_NEXT(a_accept_s1, acc, s1_v_q, "accepted item missing in stage 1")
  `IIST_ASSERT(a_frame_last, (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast, "frame end without row end")
  `IIST_ASSERT_NEXT(a_fw_src, s1_v_q, fw_v_q, "forward entry not captured")
  `IIST_ASSERT(a_diag_we, (bank_we != 2'b00) |-> s1_v_q, "diagonal write without item")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import iist_pkg::*;

  localparam int LINE      = 2048;
  localparam int CHANS_MAX = 4;
  localparam int ROWS_MAX  = 2048;
  localparam int WDOG_MAX  = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PIX_W-1:0]    s_axis_tdata = '0;    // [7:0] pixel
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [29:0] upright, [67:30] square, [97:68] tilted, [127:98] tilted_border
  logic [ODATA_W-1:0]  m_axis_tdata;
  logic                m_axis_tlast;         // row_end
  logic [0:0]          m_axis_tuser;         // [0] frame_end
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_addr_i = '0;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;

  always #1 clk_i = ~clk_i;

  integral_image_sum_square_tilted DUT (.*);

  // Pixel model: own copy of geometry, counters and line stores.
  logic [CFG_W-1:0]  mdl_width, mdl_height;
  logic [CHAN_W-1:0] mdl_chans;
  int unsigned col_q, chan_q, row_q;
  logic [RSUM_W-1:0] run_sum [CHANS_MAX];
  logic [RSQ_W-1:0]  run_sq  [CHANS_MAX];
  logic [PIX_W-1:0]  prev_pix[CHANS_MAX];
  logic [LSUM_W-1:0] held_up [CHANS_MAX];
  logic [LSUM_W-1:0] sum_ln [LINE];
  logic [LSQ_W-1:0]  sq_ln  [LINE];
  logic [LSUM_W-1:0] tilt_ln[LINE];
  logic [LSUM_W-1:0] diag_ln[LINE];

  out_item_t   expected_sums[$];
  logic [7:0]  pixel_queue[$];
  int unsigned errors = 0;
  int unsigned wdog = 0;

  // Idle knobs: percentages, and the long receiver hold-off.
  int unsigned tx_idle_pct = 0, rx_stall_pct = 0, hold_cycles = 0;

  function automatic int unsigned eff_chans();
    int unsigned n = mdl_chans;
    if (n == 0) n = 1;
    if (n > CHANS_MAX) n = CHANS_MAX;
    return n;
  endfunction

  function automatic int unsigned eff_width(int unsigned ch);
    int unsigned w = mdl_width;
    if (w == 0) w = 1;
    if (w > LINE / ch) w = LINE / ch;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h = mdl_height;
    if (h == 0) h = 1;
    if (h > ROWS_MAX) h = ROWS_MAX;
    return h;
  endfunction

  function automatic logic [LSUM_W-1:0] rd31(ref logic [LSUM_W-1:0] ln[LINE],
                                             input int unsigned i, input bit live);
    if (!live || i >= LINE) return '0;
    return ln[i];
  endfunction

  // Integrates one pixel and queues the sums it yields.
  task automatic integrate_pixel(input logic [7:0] p);
    int unsigned ch, w, h, c, k, y, here;
    bit live;
    logic [LSUM_W-1:0] up, tl, above_t, rgt, dh;
    logic [LSQ_W-1:0]  sq;
    logic [15:0]       p2;
    out_item_t         o;
    ch = eff_chans(); w = eff_width(ch); h = eff_height();
    if (chan_q >= ch) chan_q = 0;
    if (col_q >= w) col_q = 0;
    if (row_q >= h) row_q = 0;
    c = col_q; k = chan_q; y = row_q;
    live = (y != 0);
    here = c * ch + k;
    p2 = p * p;
    if (c == 0) begin
      run_sum[k] = p;
      run_sq[k]  = p2;
    end else begin
      run_sum[k] = run_sum[k] + p;
      run_sq[k]  = run_sq[k] + p2;
    end
    up = rd31(sum_ln, here, live) + run_sum[k];
    sq = (live ? sq_ln[here] : '0) + run_sq[k];
    sum_ln[here] = up;
    sq_ln[here]  = sq;
    above_t = rd31(tilt_ln, here, live);
    if (c == 0) begin
      rgt = (w > 1) ? rd31(diag_ln, here + ch, live) : '0;
      tl = above_t + p + rgt;
      o.tilted_border = above_t[TILT_W-1:0];
    end else begin
      dh = rd31(diag_ln, here, live);
      diag_ln[here - ch] = dh + prev_pix[k];
      if (c + 1 < w) begin
        rgt = rd31(diag_ln, here + ch, live);
        tl = dh + rgt + p + held_up[k];
      end else begin
        tl = dh + p + held_up[k];
        diag_ln[here] = p;
      end
      o.tilted_border = '0;
    end
    held_up[k] = above_t;
    tilt_ln[here] = tl;
    prev_pix[k] = p;
    o.upright_sum = up[SUM_W-1:0];
    o.square_sum  = sq[SQ_W-1:0];
    o.tilted_sum  = tl[TILT_W-1:0];
    o.row_end     = (k + 1 == ch) && (c + 1 == w);
    o.frame_end   = o.row_end && (y + 1 == h);
    expected_sums.push_back(o);
    chan_q = k + 1;
    if (chan_q >= ch) begin
      chan_q = 0;
      col_q = c + 1;
      if (col_q >= w) begin
        col_q = 0;
        row_q = y + 1;
        if (row_q >= h) row_q = 0;
      end
    end
  endtask

  // Driver: feeds pixels from the queue, predicting each on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) integrate_pixel(s_axis_tdata);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t got, exp_o;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_item_t'({m_axis_tuser[0], m_axis_tlast, m_axis_tdata});
        if (expected_sums.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item %h", got);
        end else begin
          exp_o = expected_sums.pop_front();
          if (got !== exp_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: up %h/%h sq %h/%h tl %h/%h bd %h/%h re %b/%b fe %b/%b",
                exp_o.upright_sum, got.upright_sum, exp_o.square_sum, got.square_sum,
                exp_o.tilted_sum, got.tilted_sum, exp_o.tilted_border, got.tilted_border,
                exp_o.row_end, got.row_end, exp_o.frame_end, got.frame_end);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || hold_cycles > 0)
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drain();
    while (pixel_queue.size() > 0 || s_axis_tvalid || expected_sums.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   mdl_width  = val;
      REG_IMAGE_HEIGHT:  mdl_height = val;
      default:           mdl_chans  = val[CHAN_W-1:0];
    endcase
    // New geometry restarts the frame at the top so no unwritten entry is read.
    col_q = 0; chan_q = 0; row_q = 0;
  endtask

  // Whole frames keep the counters aligned with the written store region.
  task automatic set_geometry(input int unsigned w, h, ch);
    write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    write_reg(REG_CHANNEL_COUNT, CFG_W'(ch));
  endtask

  task automatic queue_frames(input int unsigned n, input int unsigned mode);
    int unsigned ch, per;
    ch = eff_chans();
    per = eff_width(ch) * ch * eff_height() * n;
    repeat (per) begin
      case (mode)
        0:       pixel_queue.push_back(8'hFF);
        1:       pixel_queue.push_back(8'h00);
        default: pixel_queue.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin
    mdl_width = RST_IMAGE_WIDTH; mdl_height = RST_IMAGE_HEIGHT; mdl_chans = RST_CHANNEL_COUNT;
    col_q = 0; chan_q = 0; row_q = 0;
    for (int i = 0; i < CHANS_MAX; i++) begin
      run_sum[i] = '0; run_sq[i] = '0; prev_pix[i] = '0; held_up[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single pixel, zero registers, single column, oversized channel count, all-max and all-zero pixels.
    set_geometry(1, 1, 1);      queue_frames(2, 0); drain();
    set_geometry(0, 0, 0);      queue_frames(1, 2); drain();
    set_geometry(1, 4, 2);      queue_frames(1, 0); drain();
    set_geometry(3, 3, 7);      queue_frames(1, 2); drain();
    set_geometry(4, 2, 1);      queue_frames(1, 1); drain();

    // Random geometries under each idling phase.
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = (ph == 1 || ph == 3) ? 73 : 0;
      rx_stall_pct = (ph == 2 || ph == 3) ? 73 : 0;
      if (ph == 3) tx_idle_pct = 18;
      if (ph == 3) rx_stall_pct = 18;
      for (int g = 0; g < 6; g++) begin
        // First frame of the first phase is long enough to back up the block.
        if (ph == 0 && g == 0) begin
          set_geometry(8, 4, 2);
        end else begin
          set_geometry($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1, 4));
        end
        queue_frames(1, 2);
        if (ph == 0 && g == 0) hold_cycles = 300;
        drain();
      end
    end
    set_geometry(640, 480, 1);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
